[src/tlseq_pkg.sv]
// Package for the two-way traffic light sequencer.
// Holds shared constants, the result and configuration types, and helper functions.
// No dependencies.
package tlseq_pkg;

    localparam int unsigned CountW = 7;

    localparam logic [CountW-1:0] WR_RESET  = 7'd15;
    localparam logic [CountW-1:0] SR_RESET  = 7'd23;
    localparam logic [CountW-1:0] AMB_RESET = 7'd3;
    localparam logic [CountW-1:0] MAX_COUNT = 7'd99;
    localparam logic [3:0]        NIB_MASK  = 4'hF;

    typedef enum logic [1:0] {
        REG_WEST_RED  = 2'd0,
        REG_SOUTH_RED = 2'd1,
        REG_AMBER     = 2'd2,
        REG_MAN_AMBER = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CountW-1:0] west_red_duration;
        logic [CountW-1:0] south_red_duration;
        logic [CountW-1:0] amber_threshold;
        logic [CountW-1:0] manual_amber_duration;
    } t_cfg;

    typedef struct packed {
        logic       west_red;
        logic       west_yellow;
        logic       west_green;
        logic       south_red;
        logic       south_yellow;
        logic       south_green;
        logic [7:0] display_bcd;
        logic       display_on;
    } t_result;

    function automatic logic [CountW-1:0] load_len(input logic [CountW-1:0] v);
        logic [CountW-1:0] r;
        begin
            if (v == '0) begin
                r = 7'd1;
            end else if (v > MAX_COUNT) begin
                r = MAX_COUNT;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    // Valid for values up to 99: tens = (v * 103) >> 10.
    function automatic logic [7:0] to_bcd(input logic [CountW-1:0] v);
        logic [16:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        begin
            prod  = 17'(v) * 17'd103;
            tens  = prod[13:10];
            units = v - 7'(tens) * 7'd10;
            return {tens & NIB_MASK, units[3:0] & NIB_MASK};
        end
    endfunction

endpackage

[src/tlseq_core.sv]
// Sequencer state and per-item next-state and lamp logic.
// Depends on tlseq_pkg for the configuration and result types and the helper functions.
module tlseq_core
    import tlseq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_mode_press,
    input  logic    i_manual_hold,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_AUTO_WR = 3'd0,
        PH_AUTO_SR = 3'd1,
        PH_MAN_SY  = 3'd2,
        PH_MAN_WG  = 3'd3,
        PH_MAN_WY  = 3'd4,
        PH_MAN_SG  = 3'd5
    } t_phase;

    logic              r_manual, n_manual;
    t_phase            r_phase, n_phase;
    logic [CountW-1:0] r_count, n_count;

    t_phase            ph;
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] cnt_dec;
    logic [CountW-1:0] shown;
    t_result           res;

    always_comb begin
        ph       = r_phase;
        n_manual = r_manual;
        cnt      = r_count;
        res      = '0;
        shown    = '0;

        if (ph != PH_AUTO_SR && ph != PH_MAN_SY && ph != PH_MAN_WG
                && ph != PH_MAN_WY && ph != PH_MAN_SG) begin
            ph = PH_AUTO_WR;
        end

        if (i_mode_press) begin
            n_manual = ~r_manual;
            if (!n_manual) begin
                ph  = PH_AUTO_WR;
                cnt = load_len(i_cfg.west_red_duration);
            end else begin
                ph  = (ph == PH_AUTO_SR) ? PH_MAN_WY : PH_MAN_SY;
                cnt = load_len(i_cfg.manual_amber_duration);
            end
        end

        if (ph == PH_MAN_WG && !i_manual_hold) begin
            ph  = PH_MAN_WY;
            cnt = load_len(i_cfg.manual_amber_duration);
        end else if (ph == PH_MAN_SG && !i_manual_hold) begin
            ph  = PH_MAN_SY;
            cnt = load_len(i_cfg.manual_amber_duration);
        end

        if (cnt == '0) begin
            cnt = 7'd1;
        end
        cnt_dec = cnt - 7'd1;

        n_phase = ph;
        n_count = cnt;

        unique case (ph)
            PH_AUTO_SR: begin
                res.south_red   = 1'b1;
                res.west_green  = cnt > i_cfg.amber_threshold;
                res.west_yellow = !(cnt > i_cfg.amber_threshold);
                shown           = cnt;
                n_count         = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = PH_AUTO_WR;
                    n_count = load_len(i_cfg.west_red_duration);
                end
            end
            PH_MAN_SY: begin
                res.west_red     = 1'b1;
                res.south_yellow = 1'b1;
                shown            = cnt;
                n_count          = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = PH_MAN_WG;
                end
            end
            PH_MAN_WG: begin
                res.west_green = 1'b1;
                res.south_red  = 1'b1;
            end
            PH_MAN_WY: begin
                res.west_yellow = 1'b1;
                res.south_red   = 1'b1;
                shown           = cnt;
                n_count         = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = PH_MAN_SG;
                end
            end
            PH_MAN_SG: begin
                res.west_red    = 1'b1;
                res.south_green = 1'b1;
            end
            default: begin
                res.west_red     = 1'b1;
                res.south_green  = cnt > i_cfg.amber_threshold;
                res.south_yellow = !(cnt > i_cfg.amber_threshold);
                shown            = cnt;
                n_count          = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = PH_AUTO_SR;
                    n_count = load_len(i_cfg.south_red_duration);
                end
            end
        endcase

        if (shown > MAX_COUNT) begin
            shown = MAX_COUNT;
        end
        res.display_bcd = to_bcd(shown);
        res.display_on  = shown != '0;
        o_result        = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual <= 1'b0;
            r_phase  <= PH_AUTO_WR;
            r_count  <= load_len(WR_RESET);
        end else if (i_accept) begin
            r_manual <= n_manual;
            r_phase  <= n_phase;
            r_count  <= n_count;
        end
    end

endmodule

[src/two_way_traffic_light_sequencer_top.sv]
// Each result is registered into the output buffer when its item is accepted.
// Throughput: one item per cycle; a two-entry output buffer keeps accepting
// while one result waits, and the input stalls only when both entries are full.
// Reset is synchronous and active low: automatic west-red phase with a count of 15,
// registers at their reset values, output buffer empty.
module two_way_traffic_light_sequencer_top
    import tlseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode_press,
    input  logic        i_manual_hold,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_west_red,
    output logic        o_west_yellow,
    output logic        o_west_green,
    output logic        o_south_red,
    output logic        o_south_yellow,
    output logic        o_south_green,
    output logic [7:0]  o_display_bcd,
    output logic        o_display_on,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      r_cfg;
    t_result   core_res;
    t_result   r_out, r_skid;
    logic      r_out_valid, r_skid_valid;
    logic      accept;
    logic      out_take;
    t_reg_idx  reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = t_reg_idx'(paddr[3:2]);
    assign accept   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.west_red_duration     <= WR_RESET;
            r_cfg.south_red_duration    <= SR_RESET;
            r_cfg.amber_threshold       <= AMB_RESET;
            r_cfg.manual_amber_duration <= AMB_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_WEST_RED:  r_cfg.west_red_duration     <= pwdata[CountW-1:0];
                REG_SOUTH_RED: r_cfg.south_red_duration    <= pwdata[CountW-1:0];
                REG_AMBER:     r_cfg.amber_threshold       <= pwdata[CountW-1:0];
                REG_MAN_AMBER: r_cfg.manual_amber_duration <= pwdata[CountW-1:0];
                default:       r_cfg                       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WEST_RED:  prdata = 32'(r_cfg.west_red_duration);
            REG_SOUTH_RED: prdata = 32'(r_cfg.south_red_duration);
            REG_AMBER:     prdata = 32'(r_cfg.amber_threshold);
            REG_MAN_AMBER: prdata = 32'(r_cfg.manual_amber_duration);
            default:       prdata = '0;
        endcase
    end

    tlseq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode_press  (i_mode_press),
        .i_manual_hold (i_manual_hold),
        .i_cfg         (r_cfg),
        .o_result      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= core_res;
            end else begin
                r_skid <= core_res;
            end
        end else if (out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_west_red     = r_out.west_red;
    assign o_west_yellow  = r_out.west_yellow;
    assign o_west_green   = r_out.west_green;
    assign o_south_red    = r_out.south_red;
    assign o_south_yellow = r_out.south_yellow;
    assign o_south_green  = r_out.south_green;
    assign o_display_bcd  = r_out.display_bcd;
    assign o_display_on   = r_out.display_on;

endmodule
